@@ rtl/core/rsps_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rsps_pkg
// Shared widths, register indexes and reset values of the ramped speed
// profile block.
// ----------------------------------------------------------------------------
package rsps_pkg;

    // default width of every speed field
    localparam int SPEED_WIDTH_DEF = 20;

    // fixed field widths
    localparam int DIST_W  = 24;            // distance travelled, signed
    localparam int LEFT_W  = DIST_W + 1;    // distance left, signed
    localparam int TDIST_W = 23;            // move length
    localparam int ACCEL_W = 19;            // braking deceleration
    localparam int STEP_W  = 16;            // per-tick speed step and min speed
    localparam int TICK_W  = 16;            // tick counter
    localparam int RAMP_W  = STEP_W + TICK_W;

    // square root operand: 2 * accel * |left|
    localparam int RAD_W  = ACCEL_W + DIST_W + 1;
    localparam int ROOT_W = RAD_W / 2;

    // sequencer counter covers the longer of the two serial loops
    localparam int CNT_W = $clog2(DIST_W);

    localparam logic [TICK_W-1:0] TICK_MAX = {TICK_W{1'b1}};

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_TARGET_SPEED    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_DISTANCE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_ACCEL       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ACCEL_STEP      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_SPEED       = 3'd4;

    // register reset values
    localparam logic [TDIST_W-1:0] TDIST_RST     = '0;
    localparam logic [ACCEL_W-1:0] MAX_ACCEL_RST = 19'd32768;
    localparam logic [STEP_W-1:0]  STEP_RST      = 16'd328;
    localparam logic [STEP_W-1:0]  MIN_SPEED_RST = 16'd655;

endpackage
`default_nettype wire

@@ rtl/core/ramped_speed_profile_slew_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ramped_speed_profile_slew_top
// Trapezoidal speed profile with braking curve, ramp, minimum speed and
// per-wheel slew limiting, one control tick per request.
// ----------------------------------------------------------------------------
// Each request is one control tick and gives one result. A request is taken
// only while the block is idle, and the next request can be taken the cycle
// after the result is loaded. Most of the work is bit-serial: a shift-and-add
// multiply for 2*max_accel*|left| (the ramp product tick*accel_step runs
// alongside it), then a two-bits-per-cycle square root, then the profile
// limits, the steering offset and the slew limiter in turn. A result that is
// not taken holds the block in its last step; a new request is still taken
// while a finished result waits. Configuration writes are always accepted and
// must only be made while no request is in flight.
// ----------------------------------------------------------------------------
module ramped_speed_profile_slew_top
    import rsps_pkg::*;
#(
    parameter int SPEED_WIDTH = SPEED_WIDTH_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // configuration writes
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]          cfg_index,
    input  wire logic [CFG_DATA_W-1:0]         cfg_data,
    // tick requests
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic                          s_start_req,
    input  wire logic signed [DIST_W-1:0]      s_distance_travelled,
    input  wire logic signed [SPEED_WIDTH-1:0] s_wheel_offset,
    // results
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic signed [SPEED_WIDTH-1:0]      m_left_speed,
    output logic signed [SPEED_WIDTH-1:0]      m_right_speed,
    output logic signed [SPEED_WIDTH-1:0]      m_profile_speed,
    output logic                               m_move_done
);

    localparam int SW    = SPEED_WIDTH;
    localparam int EW    = ((SW > STEP_W) ? SW : STEP_W) + 2;
    localparam int MAG_W = (SW > RAMP_W) ? SW : RAMP_W;

    localparam logic signed [SW-1:0] SMAX = {1'b0, {(SW-1){1'b1}}};
    localparam logic signed [SW-1:0] SMIN = {1'b1, {(SW-1){1'b0}}};
    localparam logic [MAG_W-1:0] LIM_NEG = MAG_W'(1) << (SW - 1);
    localparam logic [MAG_W-1:0] LIM_POS = LIM_NEG - MAG_W'(1);

    // sequencer states
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_MUL   = 3'd1;
    localparam logic [2:0] ST_SQRT  = 3'd2;
    localparam logic [2:0] ST_PROF  = 3'd3;
    localparam logic [2:0] ST_WHEEL = 3'd4;
    localparam logic [2:0] ST_SLEW  = 3'd5;

    // saturate one extra bit back into the speed range
    function automatic logic signed [SW-1:0] sat_f(input logic signed [SW:0] v);
        logic signed [SW-1:0] r;
        if (v[SW] != v[SW-1]) begin
            r = v[SW] ? SMIN : SMAX;
        end else begin
            r = v[SW-1:0];
        end
        return r;
    endfunction

    // move now toward target by at most step
    function automatic logic signed [SW-1:0] slew_f(
        input logic signed [SW-1:0] now_v,
        input logic signed [SW-1:0] tgt_v,
        input logic [STEP_W-1:0]    step_v
    );
        logic signed [EW-1:0] n_e;
        logic signed [EW-1:0] t_e;
        logic signed [EW-1:0] s_e;
        logic signed [EW-1:0] r_e;
        n_e = EW'(now_v);
        t_e = EW'(tgt_v);
        s_e = $signed(EW'(step_v));
        if (t_e > n_e) begin
            r_e = (t_e < n_e + s_e) ? t_e : n_e + s_e;
        end else if (t_e < n_e) begin
            r_e = (t_e > n_e - s_e) ? t_e : n_e - s_e;
        end else begin
            r_e = t_e;
        end
        return r_e[SW-1:0];
    endfunction

    // control and state registers
    logic [2:0]           state_reg, state_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic                 m_valid_reg;
    logic [TICK_W-1:0]    tick_count_reg, tick_count_next;
    logic signed [SW-1:0] ts_reg;
    logic [TDIST_W-1:0]   td_reg;
    logic [ACCEL_W-1:0]   acc_reg;
    logic [STEP_W-1:0]    step_reg;
    logic [STEP_W-1:0]    mins_reg;
    logic signed [SW-1:0] left_now_reg, left_now_next;
    logic signed [SW-1:0] right_now_reg, right_now_next;

    // datapath registers
    logic [ACCEL_W-1:0]   bhi_reg, bhi_next;
    logic [DIST_W-1:0]    dmag_reg, dmag_next;
    logic [STEP_W-1:0]    rhi_reg, rhi_next;
    logic [TICK_W-1:0]    tick_reg, tick_next;
    logic [RAD_W-1:0]     x_reg, x_next;
    logic [ROOT_W+1:0]    rem_reg, rem_next;
    logic [ROOT_W-1:0]    root_reg, root_next;
    logic                 done_reg;
    logic signed [SW-1:0] off_reg;
    logic signed [SW-1:0] p_reg, p_next;
    logic signed [SW-1:0] lt_reg, lt_next;
    logic signed [SW-1:0] rt_reg, rt_next;
    logic signed [SW-1:0] m_prof_reg;
    logic                 m_done_reg;

    logic in_fire;
    logic out_free;
    logic slew_fire;

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == ST_IDLE);
    assign in_fire   = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;
    assign slew_fire = (state_reg == ST_SLEW) && out_free;

    // distance left and tick used by the ramp
    logic [LEFT_W-1:0] left_ext;
    logic [LEFT_W-1:0] left_abs;
    logic              left_done;
    logic [TICK_W-1:0] tick_use;

    always_comb begin
        left_ext  = {{(LEFT_W-TDIST_W){1'b0}}, td_reg}
                  - {s_distance_travelled[DIST_W-1], s_distance_travelled};
        left_abs  = left_ext[LEFT_W-1] ? (~left_ext + LEFT_W'(1)) : left_ext;
        left_done = left_ext[LEFT_W-1] || (left_ext == '0);
        tick_use  = s_start_req ? '0 : tick_count_reg;
        tick_count_next = (tick_use == TICK_MAX) ? TICK_MAX : tick_use + TICK_W'(1);
    end

    // serial multipliers, lsb of the multiplier shifted out each cycle
    logic [ACCEL_W:0] bsum;
    logic [STEP_W:0]  rsum;

    always_comb begin
        bsum      = {1'b0, bhi_reg} + (dmag_reg[0] ? {1'b0, acc_reg} : '0);
        bhi_next  = bsum[ACCEL_W:1];
        dmag_next = {bsum[0], dmag_reg[DIST_W-1:1]};
        rsum      = {1'b0, rhi_reg} + (tick_reg[0] ? {1'b0, step_reg} : '0);
        rhi_next  = rsum[STEP_W:1];
        tick_next = {rsum[0], tick_reg[TICK_W-1:1]};
    end

    // square root, two radicand bits per cycle
    logic [ROOT_W+3:0] sq_t;
    logic [ROOT_W+3:0] sq_trial;
    logic [ROOT_W+3:0] sq_diff;
    logic              sq_ge;

    always_comb begin
        sq_t      = {rem_reg, x_reg[RAD_W-1 -: 2]};
        sq_trial  = {2'b00, root_reg, 2'b01};
        sq_diff   = sq_t - sq_trial;
        sq_ge     = (sq_t >= sq_trial);
        rem_next  = sq_ge ? sq_diff[ROOT_W+1:0] : sq_t[ROOT_W+1:0];
        root_next = {root_reg[ROOT_W-2:0], sq_ge};
        x_next    = {x_reg[RAD_W-3:0], 2'b00};
    end

    // profile: limit the command magnitude, then floor it and restore the sign
    logic              ts_neg;
    logic [SW-1:0]     ts_u;
    logic [SW-1:0]     ts_mag;
    logic [MAG_W-1:0]  q_ts;
    logic [MAG_W-1:0]  q_brake;
    logic [MAG_W-1:0]  q_ramp;
    logic [MAG_W-1:0]  q_min;
    logic [MAG_W-1:0]  q1;
    logic [MAG_W-1:0]  q2;
    logic [MAG_W-1:0]  q3;

    always_comb begin
        ts_u    = ts_reg;
        ts_neg  = ts_reg[SW-1];
        ts_mag  = ts_neg ? (~ts_u + SW'(1)) : ts_u;
        q_ts    = MAG_W'(ts_mag);
        q_brake = MAG_W'(root_reg);
        q_ramp  = MAG_W'({rhi_reg, tick_reg});
        q_min   = MAG_W'(mins_reg);
        q1      = (q_brake < q_ts) ? q_brake : q_ts;
        q2      = (q_ramp < q1) ? q_ramp : q1;
        q3      = (q2 < q_min) ? q_min : q2;
        if (!ts_neg) begin
            p_next = (q3 > LIM_POS) ? SMAX : q3[SW-1:0];
        end else begin
            p_next = (q3 > LIM_NEG) ? SMIN : (~q3[SW-1:0] + SW'(1));
        end
    end

    // steering offset per wheel, then slew limiting
    always_comb begin
        lt_next        = sat_f((SW+1)'(p_reg) - (SW+1)'(off_reg));
        rt_next        = sat_f((SW+1)'(p_reg) + (SW+1)'(off_reg));
        left_now_next  = slew_f(left_now_reg, lt_reg, step_reg);
        right_now_next = slew_f(right_now_reg, rt_reg, step_reg);
    end

    // sequencer
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    state_next = ST_MUL;
                    cnt_next   = '0;
                end
            end
            ST_MUL: begin
                if (cnt_reg == CNT_W'(DIST_W - 1)) begin
                    state_next = ST_SQRT;
                    cnt_next   = '0;
                end else begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            ST_SQRT: begin
                if (cnt_reg == CNT_W'(ROOT_W - 1)) begin
                    state_next = ST_PROF;
                end else begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            ST_PROF: begin
                state_next = ST_WHEEL;
            end
            ST_WHEEL: begin
                state_next = ST_SLEW;
            end
            ST_SLEW: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state, configuration and kept wheel speeds
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            cnt_reg        <= '0;
            m_valid_reg    <= 1'b0;
            tick_count_reg <= '0;
            ts_reg         <= '0;
            td_reg         <= TDIST_RST;
            acc_reg        <= MAX_ACCEL_RST;
            step_reg       <= STEP_RST;
            mins_reg       <= MIN_SPEED_RST;
            left_now_reg   <= '0;
            right_now_reg  <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            if (in_fire) begin
                tick_count_reg <= tick_count_next;
            end
            if (slew_fire) begin
                m_valid_reg   <= 1'b1;
                left_now_reg  <= left_now_next;
                right_now_reg <= right_now_next;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (cfg_valid) begin
                unique case (cfg_index)
                    REG_TARGET_SPEED:    ts_reg   <= cfg_data[SW-1:0];
                    REG_TARGET_DISTANCE: td_reg   <= cfg_data[TDIST_W-1:0];
                    REG_MAX_ACCEL:       acc_reg  <= cfg_data[ACCEL_W-1:0];
                    REG_ACCEL_STEP:      step_reg <= cfg_data[STEP_W-1:0];
                    REG_MIN_SPEED:       mins_reg <= cfg_data[STEP_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        if (in_fire) begin
            bhi_reg  <= '0;
            dmag_reg <= left_abs[DIST_W-1:0];
            rhi_reg  <= '0;
            tick_reg <= tick_use;
            done_reg <= left_done;
            off_reg  <= s_wheel_offset;
        end
        if (state_reg == ST_MUL) begin
            bhi_reg  <= bhi_next;
            dmag_reg <= dmag_next;
            if (cnt_reg < CNT_W'(TICK_W)) begin
                rhi_reg  <= rhi_next;
                tick_reg <= tick_next;
            end
            // radicand is twice the finished product
            if (cnt_reg == CNT_W'(DIST_W - 1)) begin
                x_reg    <= {bhi_next, dmag_next, 1'b0};
                rem_reg  <= '0;
                root_reg <= '0;
            end
        end
        if (state_reg == ST_SQRT) begin
            x_reg    <= x_next;
            rem_reg  <= rem_next;
            root_reg <= root_next;
        end
        if (state_reg == ST_PROF) begin
            p_reg <= p_next;
        end
        if (state_reg == ST_WHEEL) begin
            lt_reg <= lt_next;
            rt_reg <= rt_next;
        end
        if (slew_fire) begin
            m_prof_reg <= p_reg;
            m_done_reg <= done_reg;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_left_speed    = left_now_reg;
    assign m_right_speed   = right_now_reg;
    assign m_profile_speed = m_prof_reg;
    assign m_move_done     = m_done_reg;

endmodule
`default_nettype wire

@@ rtl/core/rsps_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rsps_checker
// Port-level checks of the ramped speed profile block, bound to its top level.
// ----------------------------------------------------------------------------
module rsps_checker
    import rsps_pkg::*;
#(
    parameter int SPEED_WIDTH = SPEED_WIDTH_DEF
) (
    input wire logic                          aclk,
    input wire logic                          aresetn,
    input wire logic                          cfg_ready,
    input wire logic                          s_valid,
    input wire logic                          s_ready,
    input wire logic                          m_valid,
    input wire logic                          m_ready,
    input wire logic signed [SPEED_WIDTH-1:0] m_left_speed,
    input wire logic signed [SPEED_WIDTH-1:0] m_right_speed,
    input wire logic signed [SPEED_WIDTH-1:0] m_profile_speed,
    input wire logic                          m_move_done
);

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_left_speed)
            && $stable(m_right_speed) && $stable(m_profile_speed)
            && $stable(m_move_done))
        else $error("result changed while stalled");

    // one request in flight: no request taken right after another
    a_one_request: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request taken while busy");

    // a result never follows its request in the next cycle
    a_no_early_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !$rose(m_valid))
        else $error("result too early");

    // leaving reset, ready for a request with no result pending
    a_reset_idle: assert property (@(posedge aclk)
        $rose(aresetn) |-> s_ready && !m_valid && cfg_ready)
        else $error("not idle after reset");

endmodule

bind ramped_speed_profile_slew_top rsps_checker #(
    .SPEED_WIDTH(SPEED_WIDTH)
) u_rsps_checker (.*);
`default_nettype wire

@@ test/ramped_speed_profile_slew_top_tb.sv @@
// ----------------------------------------------------------------------------
// ramped_speed_profile_slew_top_tb
// Self-checking bench for the ramped speed profile with wheel slew limiting.
// Control ticks go in over the request channel. An in-bench model keeps its
// own copy of the registers, tick count and wheel speeds, works out the
// expected wheel, profile and done values of every accepted tick, and the
// result monitor compares each returned result with the oldest of them.
// Directed ticks cover field extremes, reset values, negative commands, a zero
// step and a zero braking limit. Random moves follow, under random settings,
// with random idling on both channels.
// ----------------------------------------------------------------------------
module ramped_speed_profile_slew_top_tb;
    import rsps_pkg::*;

    localparam int SW          = SPEED_WIDTH_DEF;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int DRAIN_WAIT  = 60;
    localparam longint SPD_MAX = (64'sd1 <<< (SW - 1)) - 1;
    localparam longint SPD_MIN = -SPD_MAX - 1;
    localparam longint DIST_MAX = (64'sd1 <<< (DIST_W - 1)) - 1;

    typedef struct {
        longint left_speed;
        longint right_speed;
        longint profile_speed;
        logic   move_done;
    } wheel_cmd_t;

    logic                        aclk;
    logic                        aresetn;
    logic                        cfg_valid;
    logic                        cfg_ready;
    logic [CFG_IDX_W-1:0]        cfg_index;
    logic [CFG_DATA_W-1:0]       cfg_data;
    logic                        s_valid;
    logic                        s_ready;
    logic                        s_start_req;
    logic signed [DIST_W-1:0]    s_distance_travelled;
    logic signed [SW-1:0]        s_wheel_offset;
    logic                        m_valid;
    logic                        m_ready;
    logic signed [SW-1:0]        m_left_speed;
    logic signed [SW-1:0]        m_right_speed;
    logic signed [SW-1:0]        m_profile_speed;
    logic                        m_move_done;

    // register mirror
    longint                      reg_target_speed;
    longint                      reg_target_distance;
    longint                      reg_max_accel;
    longint                      reg_accel_step;
    longint                      reg_min_speed;

    // model state
    longint                      kept_left;
    longint                      kept_right;
    longint                      ticks_held;

    wheel_cmd_t                  pending_cmds[$];
    int                          error_count;
    int                          cycle_count;
    bit                          no_idle;

    ramped_speed_profile_slew_top #(
        .SPEED_WIDTH(SW)
    ) dut (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cfg_valid           (cfg_valid),
        .cfg_ready           (cfg_ready),
        .cfg_index           (cfg_index),
        .cfg_data            (cfg_data),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_start_req         (s_start_req),
        .s_distance_travelled(s_distance_travelled),
        .s_wheel_offset      (s_wheel_offset),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_left_speed        (m_left_speed),
        .m_right_speed       (m_right_speed),
        .m_profile_speed     (m_profile_speed),
        .m_move_done         (m_move_done)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // run limit
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // result side backpressure
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (no_idle) begin
            m_ready <= 1'b1;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= 37);
        end
    end

    // ------------------------------------------------------------------
    // model helpers
    // ------------------------------------------------------------------

    function automatic longint clamp_speed(longint v);
        if (v > SPD_MAX) return SPD_MAX;
        if (v < SPD_MIN) return SPD_MIN;
        return v;
    endfunction

    // floor square root, one result bit at a time from the top
    function automatic longint unsigned floor_root(longint unsigned x);
        longint unsigned r;
        longint unsigned c;
        r = 0;
        for (int b = 31; b >= 0; b--) begin
            c = r | (64'd1 << b);
            if (c * c <= x) r = c;
        end
        return r;
    endfunction

    function automatic longint slew_toward(longint now, longint goal, longint step);
        if (goal > now) return (goal < now + step) ? goal : now + step;
        if (goal < now) return (goal > now - step) ? goal : now - step;
        return goal;
    endfunction

    // expected result of one tick, advances the model state
    function automatic wheel_cmd_t predict_wheel_cmd(bit start, longint travelled,
                                                     longint offset);
        wheel_cmd_t cmd;
        longint left;
        longint unsigned mag;
        longint tick;
        longint brake;
        longint ramp;
        longint p;
        left = reg_target_distance - travelled;
        mag = (left < 0) ? -left : left;
        tick = start ? 0 : ticks_held;
        ticks_held = (tick >= TICK_MAX) ? TICK_MAX : tick + 1;
        brake = floor_root(2 * reg_max_accel * mag);
        ramp = reg_accel_step * tick;
        p = reg_target_speed;
        if (reg_target_speed >= 0) begin
            if (brake < p) p = brake;
            if (ramp < p) p = ramp;
            if (p < reg_min_speed) p = reg_min_speed;
        end else begin
            if (-brake > p) p = -brake;
            if (-ramp > p) p = -ramp;
            if (p > -reg_min_speed) p = -reg_min_speed;
        end
        p = clamp_speed(p);
        kept_left = slew_toward(kept_left, clamp_speed(p - offset), reg_accel_step);
        kept_right = slew_toward(kept_right, clamp_speed(p + offset), reg_accel_step);
        cmd.left_speed = kept_left;
        cmd.right_speed = kept_right;
        cmd.profile_speed = p;
        cmd.move_done = (left <= 0);
        return cmd;
    endfunction

    // ------------------------------------------------------------------
    // result monitor
    // ------------------------------------------------------------------

    task automatic compare_field(string name, longint want, longint got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
            error_count++;
        end
    endtask

    always @(posedge aclk) begin : check_result
        wheel_cmd_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_cmds.size() == 0) begin
                $display("%0t: result with none expected, expected none actual %0d/%0d/%0d/%0d",
                         $time, m_left_speed, m_right_speed, m_profile_speed, m_move_done);
                error_count++;
            end else begin
                want = pending_cmds.pop_front();
                compare_field("left_speed", want.left_speed, m_left_speed);
                compare_field("right_speed", want.right_speed, m_right_speed);
                compare_field("profile_speed", want.profile_speed, m_profile_speed);
                compare_field("move_done", want.move_done, m_move_done);
            end
        end
    end

    // ------------------------------------------------------------------
    // channel drivers
    // ------------------------------------------------------------------

    // register write, only while nothing is in flight
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, longint value);
        logic signed [SW-1:0] speed_bits;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[CFG_DATA_W-1:0];
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_TARGET_SPEED: begin
                speed_bits = value[SW-1:0];
                reg_target_speed = speed_bits;
            end
            REG_TARGET_DISTANCE: reg_target_distance = value & ((64'd1 << TDIST_W) - 1);
            REG_MAX_ACCEL:       reg_max_accel = value & ((64'd1 << ACCEL_W) - 1);
            REG_ACCEL_STEP:      reg_accel_step = value & ((64'd1 << STEP_W) - 1);
            REG_MIN_SPEED:       reg_min_speed = value & ((64'd1 << STEP_W) - 1);
            default: ;
        endcase
        @(posedge aclk);
    endtask

    task automatic write_all_regs(longint ts, longint td, longint acc, longint st, longint ms);
        write_reg(REG_TARGET_SPEED, ts);
        write_reg(REG_TARGET_DISTANCE, td);
        write_reg(REG_MAX_ACCEL, acc);
        write_reg(REG_ACCEL_STEP, st);
        write_reg(REG_MIN_SPEED, ms);
    endtask

    // one tick request; valid stays high afterwards unless a gap follows
    task automatic send_tick(bit start, logic signed [DIST_W-1:0] travelled,
                             logic signed [SW-1:0] offset);
        int gap;
        gap = 0;
        if (!no_idle && $urandom_range(0, 99) < 37) begin
            gap = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 60) : $urandom_range(1, 6);
        end
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid              <= 1'b1;
        s_start_req          <= start;
        s_distance_travelled <= travelled;
        s_wheel_offset       <= offset;
        do @(posedge aclk); while (!s_ready);
        pending_cmds.push_back(predict_wheel_cmd(start, travelled, offset));
    endtask

    // wait until every expected result has come back
    task automatic drain;
        s_valid <= 1'b0;
        while (pending_cmds.size() > 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // reset register values, default command of zero gives the min speed
    task automatic test_reset_values;
        send_tick(1'b1, 24'sd0, 20'sd0);
        send_tick(1'b0, 24'sd1000, 20'sd300);
        send_tick(1'b0, -24'sd5000, -20'sd300);
        drain();
    endtask

    // positive command with extreme fields, wheel targets saturate
    task automatic test_field_extremes;
        write_all_regs(SPD_MAX, 8388607, 262144, 65535, 0);
        send_tick(1'b1, -24'sd8388608, 20'sd524287);
        send_tick(1'b0, -24'sd8388608, -20'sd524288);
        send_tick(1'b0, 24'sd0, 20'sd524287);
        send_tick(1'b0, 24'sd8388607, -20'sd524288);
        send_tick(1'b0, 24'sd8388606, 20'sd0);
        send_tick(1'b0, 24'sd8388607, 20'sd0);
        drain();
    endtask

    // negative command is mirrored and capped at minus the min speed
    task automatic test_negative_command;
        write_all_regs(SPD_MIN, 100000, 262144, 65535, 65535);
        send_tick(1'b1, 24'sd0, 20'sd524287);
        send_tick(1'b0, 24'sd50000, -20'sd524288);
        send_tick(1'b0, 24'sd100000, 20'sd0);
        drain();
        write_all_regs(-65536, 4000000, 32768, 500, 655);
        send_tick(1'b1, 24'sd0, 20'sd1000);
        send_tick(1'b0, 24'sd10, -20'sd1000);
        send_tick(1'b0, 24'sd8388607, 20'sd0);
        drain();
    endtask

    // zero step holds both wheels, zero accel leaves only the min speed
    task automatic test_zero_step_and_accel;
        write_all_regs(131072, 1000000, 65536, 0, 1000);
        send_tick(1'b1, 24'sd0, 20'sd2000);
        send_tick(1'b0, 24'sd500, -20'sd2000);
        drain();
        write_all_regs(131072, 1000000, 0, 2000, 1000);
        send_tick(1'b1, 24'sd0, 20'sd0);
        send_tick(1'b0, 24'sd0, 20'sd0);
        send_tick(1'b0, 24'sd1000000, 20'sd0);
        drain();
    endtask

    // random settings, extremes now and then
    task automatic randomize_regs;
        longint ts;
        longint td;
        longint acc;
        longint st;
        longint ms;
        case ($urandom_range(0, 9))
            0: ts = SPD_MAX;
            1: ts = SPD_MIN;
            2, 3, 4, 5: ts = $urandom_range(0, 4 * 65536);
            6, 7, 8: ts = -longint'($urandom_range(0, 4 * 65536));
            default: ts = $urandom_range(0, (1 << SW) - 1);
        endcase
        case ($urandom_range(0, 9))
            0: td = 0;
            1: td = 8388607;
            default: td = $urandom_range(1000, 1 << 21);
        endcase
        case ($urandom_range(0, 9))
            0: acc = 0;
            1: acc = 262144;
            default: acc = $urandom_range(1000, 131072);
        endcase
        case ($urandom_range(0, 9))
            0: st = 0;
            1: st = 65535;
            default: st = $urandom_range(1, 4000);
        endcase
        case ($urandom_range(0, 9))
            0: ms = 0;
            1: ms = 65535;
            default: ms = $urandom_range(0, 2000);
        endcase
        write_all_regs(ts, td, acc, st, ms);
    endtask

    // one move: start tick, distance growing past the target, some noise
    task automatic run_move(int n_ticks);
        longint travelled;
        longint inc;
        longint offset;
        logic [DIST_W-1:0] raw_dist;
        logic [SW-1:0] raw_off;
        travelled = 0;
        inc = reg_target_distance / 60 + 1;
        for (int i = 0; i < n_ticks; i++) begin
            if (i > 0 && $urandom_range(0, 9) == 0) begin
                raw_dist = DIST_W'($urandom);
                raw_off = SW'($urandom);
                send_tick(1'($urandom_range(0, 1)), raw_dist, raw_off);
            end else begin
                if ($urandom_range(0, 19) == 0) begin
                    raw_off = SW'($urandom);
                    offset = $signed(raw_off);
                end else begin
                    offset = longint'($urandom_range(0, 8192)) - 4096;
                end
                send_tick(i == 0 || $urandom_range(0, 99) == 0, DIST_W'(travelled),
                          SW'(offset));
                travelled = travelled + $urandom_range(0, 2 * inc);
                if (travelled > DIST_MAX) travelled = DIST_MAX;
            end
        end
        drain();
    endtask

    task automatic test_random_moves(int n_moves);
        for (int k = 0; k < n_moves; k++) begin
            randomize_regs();
            run_move($urandom_range(60, 140));
        end
    endtask

    // back to back requests and results with no idling
    task automatic test_no_idle_stretch;
        no_idle = 1'b1;
        randomize_regs();
        run_move(150);
        no_idle = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial begin
        error_count = 0;
        cycle_count = 0;
        no_idle = 1'b0;
        reg_target_speed = 0;
        reg_target_distance = TDIST_RST;
        reg_max_accel = MAX_ACCEL_RST;
        reg_accel_step = STEP_RST;
        reg_min_speed = MIN_SPEED_RST;
        kept_left = 0;
        kept_right = 0;
        ticks_held = 0;
        aresetn              <= 1'b0;
        cfg_valid            <= 1'b0;
        cfg_index            <= REG_TARGET_SPEED;
        cfg_data             <= '0;
        s_valid              <= 1'b0;
        s_start_req          <= 1'b0;
        s_distance_travelled <= '0;
        s_wheel_offset       <= '0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_values();
        test_field_extremes();
        test_negative_command();
        test_zero_step_and_accel();
        test_random_moves(5);
        test_no_idle_stretch();
        test_random_moves(5);

        drain();
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (error_count == 0 && pending_cmds.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
